### design/hsv_pkg.sv
// shared types, constants and arithmetic helpers for the hsv to rgb block
// no dependencies
package hsv_pkg;

  localparam logic [1:0] OP_SET     = 2'd0;
  localparam logic [1:0] OP_ADD_HUE = 2'd1;
  localparam logic [1:0] OP_ADD_SAT = 2'd2;
  localparam logic [1:0] OP_ADD_BRI = 2'd3;

  localparam logic [12:0] ONE_FX     = 13'd4096;
  localparam logic [12:0] HUE_FULL   = 13'd5760;
  localparam logic [10:0] HUE_SECTOR = 11'd960;
  localparam int          VAL_W      = 35;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] hue_value;
    logic signed [15:0] sat_value;
    logic signed [15:0] bright_value;
    logic signed [15:0] delta;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic scale;
    logic div;
  } cmd_t;

  typedef struct packed {
    logic [2:0] sector;
    logic [9:0] span;
  } hue_pos_t;

  // reduce a signed hue to 0..5759
  function automatic logic [12:0] wrap_hue(input logic signed [16:0] h);
    logic [17:0] u;
    logic [9:0]  t;
    logic [19:0] p;
    logic [3:0]  q;
    logic [17:0] qm;
    logic [17:0] r;
    u  = {h[16], h} + 18'd34560;
    t  = u[16:7];
    p  = 20'(t) * 20'd1457;
    q  = p[19:16];
    qm = 18'(q) * 18'(HUE_FULL);
    r  = u - qm;
    return r[12:0];
  endfunction

  function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    logic [16:0] s;
    s = {a[15], a} + {b[15], b};
    if (s[16] != s[15]) begin
      return s[16] ? 16'sh8000 : 16'sh7fff;
    end
    return s[15:0];
  endfunction

  function automatic logic [12:0] clamp_unit(input logic signed [15:0] v);
    if (v[15]) begin
      return 13'd0;
    end
    if (v[14:0] > 15'(ONE_FX)) begin
      return ONE_FX;
    end
    return v[12:0];
  endfunction

  function automatic hue_pos_t hue_split(input logic [12:0] h);
    hue_pos_t   pos;
    logic [12:0] hh;
    if (h >= 13'd4800) begin
      pos.sector = 3'd5;
    end else if (h >= 13'd3840) begin
      pos.sector = 3'd4;
    end else if (h >= 13'd2880) begin
      pos.sector = 3'd3;
    end else if (h >= 13'd1920) begin
      pos.sector = 3'd2;
    end else if (h >= 13'(HUE_SECTOR)) begin
      pos.sector = 3'd1;
    end else begin
      pos.sector = 3'd0;
    end
    if (h >= 13'd3840) begin
      hh = h - 13'd3840;
    end else if (h >= 13'd1920) begin
      hh = h - 13'd1920;
    end else begin
      hh = h;
    end
    if (hh >= 13'(HUE_SECTOR)) begin
      pos.span = 10'(hh - 13'(HUE_SECTOR));
    end else begin
      pos.span = 10'(13'(HUE_SECTOR) - hh);
    end
    return pos;
  endfunction

  // floor((val*255 + 15*2^29) / 2^30)
  function automatic logic [11:0] scale_q(input logic [VAL_W-1:0] val);
    logic [VAL_W+8:0] t;
    t = {1'b0, val, 8'b0} - {9'b0, val} + (VAL_W+9)'(64'd8053063680);
    return t[41:30];
  endfunction

  // floor(q / 15) for q below 3840
  function automatic logic [7:0] div15(input logic [11:0] q);
    logic [23:0] p;
    p = 24'(q) * 24'd2185;
    return p[22:15];
  endfunction

endpackage

### design/hsv_ctrl.sv
// sequencer for the hsv to rgb block: accept, two multiply steps, scale, divide
// depends on hsv_pkg
module hsv_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output hsv_pkg::cmd_t cmd
);
  import hsv_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_SCALE,
    S_DIV
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) || ((state_r == S_DIV) && slot_free);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load  = in_valid && in_ready;
    cmd.mul1  = (state_r == S_MUL1);
    cmd.mul2  = (state_r == S_MUL2);
    cmd.scale = (state_r == S_SCALE);
    cmd.div   = (state_r == S_DIV) && slot_free;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_MUL1;
        end
      end
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_DIV;
      S_DIV: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = in_valid ? S_MUL1 : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_MUL1))
    else $error("accepted request did not start the multiply step");

  a_div_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div |-> (!out_valid_r || out_ready))
    else $error("result written over an untaken result");

  a_div_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div |=> out_valid_r)
    else $error("written result not shown");

  a_cmd_steps: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.mul1, cmd.mul2, cmd.scale, cmd.div}))
    else $error("more than one datapath step at once");

endmodule

### design/hsv_dpath.sv
// color state registers, shared multiplier and rgb scaling datapath
// depends on hsv_pkg
module hsv_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  hsv_pkg::cmd_t     cmd,
  input  hsv_pkg::in_item_t in_data,
  output hsv_pkg::out_item_t out_data
);
  import hsv_pkg::*;

  logic [12:0]        hue_r, hue_nxt;
  logic signed [15:0] sat_r, sat_nxt;
  logic signed [15:0] bri_r, bri_nxt;
  logic signed [16:0] hue_sum;

  logic [24:0] vs_r;
  logic [12:0] vc_r;
  hue_pos_t    pos_r;
  logic [33:0] px_r;
  logic [11:0] qr_r, qg_r, qb_r;
  out_item_t   out_r;

  logic [24:0] mul_a;
  logic [12:0] mul_b;
  logic [37:0] mul_p;

  logic [VAL_W-1:0] c_val, x_val, z_val;
  logic [VAL_W-1:0] vr, vg, vb;

  // state update
  assign hue_sum = $signed({4'b0, hue_r}) + $signed({in_data.delta[15], in_data.delta});

  always_comb begin
    hue_nxt = hue_r;
    sat_nxt = sat_r;
    bri_nxt = bri_r;
    if (cmd.load) begin
      case (in_data.opcode)
        OP_SET: begin
          hue_nxt = wrap_hue({in_data.hue_value[15], in_data.hue_value});
          sat_nxt = in_data.sat_value;
          bri_nxt = in_data.bright_value;
        end
        OP_ADD_HUE: hue_nxt = wrap_hue(hue_sum);
        OP_ADD_SAT: sat_nxt = sat_add(sat_r, in_data.delta);
        default:    bri_nxt = sat_add(bri_r, in_data.delta);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_r <= 13'd0;
      sat_r <= 16'(ONE_FX);
      bri_r <= 16'(ONE_FX);
    end else begin
      hue_r <= hue_nxt;
      sat_r <= sat_nxt;
      bri_r <= bri_nxt;
    end
  end

  // shared multiplier: v*s, then v*s*span
  always_comb begin
    if (cmd.mul2) begin
      mul_a = vs_r;
      mul_b = {3'b0, pos_r.span};
    end else begin
      mul_a = {12'b0, clamp_unit(bri_r)};
      mul_b = clamp_unit(sat_r);
    end
    mul_p = 38'(mul_a) * 38'(mul_b);
  end

  // per-component numerators over 4096*4096*960
  always_comb begin
    c_val = (VAL_W'(vc_r) << 22) - (VAL_W'(vc_r) << 18);
    x_val = c_val - VAL_W'(px_r);
    z_val = c_val - ((VAL_W'(vs_r) << 10) - (VAL_W'(vs_r) << 6));
    case (pos_r.sector)
      3'd0: begin vr = c_val; vg = x_val; vb = z_val; end
      3'd1: begin vr = x_val; vg = c_val; vb = z_val; end
      3'd2: begin vr = z_val; vg = c_val; vb = x_val; end
      3'd3: begin vr = z_val; vg = x_val; vb = c_val; end
      3'd4: begin vr = x_val; vg = z_val; vb = c_val; end
      default: begin vr = c_val; vg = z_val; vb = x_val; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      vs_r  <= mul_p[24:0];
      vc_r  <= clamp_unit(bri_r);
      pos_r <= hue_split(hue_r);
    end
    if (cmd.mul2) begin
      px_r <= mul_p[33:0];
    end
    if (cmd.scale) begin
      qr_r <= scale_q(vr);
      qg_r <= scale_q(vg);
      qb_r <= scale_q(vb);
    end
    if (cmd.div) begin
      out_r.red   <= div15(qr_r);
      out_r.green <= div15(qg_r);
      out_r.blue  <= div15(qb_r);
    end
  end

  assign out_data = out_r;

endmodule

### design/hsv_color_state_to_rgb.sv
// hsv color state with rgb output: top level joining sequencer and datapath
// throughput: a new request is taken only as the last one leaves the divide
//   step, set by the single shared multiplier and the multiply, multiply,
//   scale, divide sequence; the divide step waits while a result is untaken
// reset: synchronous active-low rst_n; hue 0, saturation and brightness 1.0
// depends on hsv_pkg, hsv_ctrl, hsv_dpath
module hsv_color_state_to_rgb (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hsv_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hsv_pkg::out_item_t out_data
);
  import hsv_pkg::*;

  cmd_t cmd;

  hsv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  hsv_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

### tb/tb_hsv_color_state_to_rgb.sv
// testbench for hsv_color_state_to_rgb: color state updates checked against rgb results
// holds its own hsv state and rgb conversion; depends on hsv_pkg and the block's rtl
`timescale 1ns / 1ps

module tb;
  import hsv_pkg::*;

  localparam int HUE_UNITS    = 5760;
  localparam int SECTOR_UNITS = 960;
  localparam int UNIT_ONE     = 4096;
  localparam int RANDOM_REQS  = 1150;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 400000;

  class hsv_color_model;
    int         hue;
    int         sat;
    int         bri;
    out_item_t  rgb_due_q[$];
    int         op_count[4];
    int         checked;
    int         errors;

    function new();
      hue = 0;
      sat = UNIT_ONE;
      bri = UNIT_ONE;
      checked = 0;
      errors = 0;
      foreach (op_count[i]) op_count[i] = 0;
    endfunction

    function int wrap_degrees(int h);
      int r;
      r = h % HUE_UNITS;
      if (r < 0) r += HUE_UNITS;
      return r;
    endfunction

    function int clip16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function longint unsigned unit_clamp(int v);
      if (v < 0) return 0;
      if (v > UNIT_ONE) return UNIT_ONE;
      return v;
    endfunction

    function logic [7:0] quant8(longint unsigned num);
      longint unsigned den;
      longint unsigned q;
      den = 64'd16106127360;
      q = (num * 255 + den / 2) / den;
      if (q > 255) q = 255;
      return q[7:0];
    endfunction

    function out_item_t predict_rgb();
      out_item_t       rgb;
      longint unsigned s, v, c, x, m, k, r1, g1, b1;
      int              hh, span;
      s = unit_clamp(sat);
      v = unit_clamp(bri);
      hh = hue % (2 * SECTOR_UNITS);
      span = (hh >= SECTOR_UNITS) ? hh - SECTOR_UNITS : SECTOR_UNITS - hh;
      k = 64'(SECTOR_UNITS - span);
      c = v * s * SECTOR_UNITS;
      x = v * s * k;
      m = (v * UNIT_ONE - v * s) * SECTOR_UNITS;
      case (hue / SECTOR_UNITS)
        0: begin r1 = c; g1 = x; b1 = 0; end
        1: begin r1 = x; g1 = c; b1 = 0; end
        2: begin r1 = 0; g1 = c; b1 = x; end
        3: begin r1 = 0; g1 = x; b1 = c; end
        4: begin r1 = x; g1 = 0; b1 = c; end
        default: begin r1 = c; g1 = 0; b1 = x; end
      endcase
      rgb.red   = quant8(r1 + m);
      rgb.green = quant8(g1 + m);
      rgb.blue  = quant8(b1 + m);
      return rgb;
    endfunction

    function void note_request(in_item_t req);
      int d;
      d = $signed(req.delta);
      case (req.opcode)
        OP_SET: begin
          hue = wrap_degrees($signed(req.hue_value));
          sat = $signed(req.sat_value);
          bri = $signed(req.bright_value);
        end
        OP_ADD_HUE: hue = wrap_degrees(hue + d);
        OP_ADD_SAT: sat = clip16(sat + d);
        OP_ADD_BRI: bri = clip16(bri + d);
        default: ;
      endcase
      op_count[req.opcode]++;
      rgb_due_q.push_back(predict_rgb());
    endfunction

    function void check_color(out_item_t got);
      out_item_t want;
      if (rgb_due_q.size() == 0) begin
        $error("result with no request outstanding: %h", got);
        errors++;
        return;
      end
      want = rgb_due_q.pop_front();
      checked++;
      if (got.red !== want.red) begin
        $error("red mismatch: expected %0d, actual %0d", want.red, got.red);
        errors++;
      end
      if (got.green !== want.green) begin
        $error("green mismatch: expected %0d, actual %0d", want.green, got.green);
        errors++;
      end
      if (got.blue !== want.blue) begin
        $error("blue mismatch: expected %0d, actual %0d", want.blue, got.blue);
        errors++;
      end
    endfunction

    function int pending();
      return rgb_due_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;

  hsv_color_model colors = new();
  int             cycle_count = 0;
  bit             hold_off_req = 1'b0;
  int             hold_offs_done = 0;

  hsv_color_state_to_rgb dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      colors.check_color(out_data);
    end
  end

  // receiver: stretches of free flow, random stalls and sparse acceptance, plus one long hold-off on request
  initial begin
    int mode;
    int len;
    wait (rst_n);
    forever begin
      if (hold_off_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        hold_offs_done++;
      end else begin
        mode = $urandom_range(0, 2);
        len = $urandom_range(5, 60);
        repeat (len) begin
          @(negedge clk);
          case (mode)
            0: out_ready = 1'b1;
            1: out_ready = $urandom_range(0, 1);
            default: out_ready = ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  function automatic in_item_t make_request(logic [1:0] op, logic [15:0] h, logic [15:0] s,
                                            logic [15:0] v, logic [15:0] d);
    in_item_t req;
    req.opcode = op;
    req.hue_value = h;
    req.sat_value = s;
    req.bright_value = v;
    req.delta = d;
    return req;
  endfunction

  function automatic logic [15:0] pick_unit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 16'($urandom_range(0, UNIT_ONE));
    if (r < 85) return 16'($urandom_range(0, UNIT_ONE + 128) - 64);
    return 16'($urandom);
  endfunction

  function automatic in_item_t random_request();
    in_item_t req;
    int       r;
    req = make_request(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom));
    r = $urandom_range(0, 99);
    if (r < 25) begin
      req.opcode = OP_SET;
      if ($urandom_range(0, 9) < 7) req.hue_value = 16'($urandom_range(0, HUE_UNITS - 1));
      req.sat_value = pick_unit();
      req.bright_value = pick_unit();
    end else begin
      case ($urandom_range(0, 2))
        0: req.opcode = OP_ADD_HUE;
        1: req.opcode = OP_ADD_SAT;
        default: req.opcode = OP_ADD_BRI;
      endcase
      r = $urandom_range(0, 99);
      if (r < 35) req.delta = 16'($urandom_range(0, 32) - 16);
      else if (r < 80) req.delta = 16'($urandom_range(0, 1024) - 512);
    end
    return req;
  endfunction

  // request is held until the handshake, then the driver returns at the next falling edge
  task automatic send_request(in_item_t req);
    in_valid = 1'b1;
    in_data = req;
    do @(posedge clk); while (!in_ready);
    colors.note_request(req);
    @(negedge clk);
  endtask

  task automatic idle_sender(int cycles);
    in_valid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  initial begin
    int sent;
    int burst;
    int gap;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // primary and secondary hues at full saturation, sector boundaries
    send_request(make_request(OP_SET, 16'd0, 16'd4096, 16'd4096, 16'($urandom)));
    send_request(make_request(OP_SET, 16'd960, 16'd4096, 16'd4096, 16'($urandom)));
    send_request(make_request(OP_SET, 16'd1920, 16'd4096, 16'd4096, 16'($urandom)));
    send_request(make_request(OP_SET, 16'd2880, 16'd4096, 16'd4096, 16'($urandom)));
    idle_sender(3);
    send_request(make_request(OP_SET, 16'd3840, 16'd4096, 16'd4096, 16'($urandom)));
    send_request(make_request(OP_SET, 16'd4800, 16'd4096, 16'd4096, 16'($urandom)));
    send_request(make_request(OP_SET, 16'd5759, 16'd4096, 16'd4096, 16'($urandom)));
    // hue wrap on load, out of range saturation and brightness
    send_request(make_request(OP_SET, 16'hffff, 16'h7fff, 16'h7fff, 16'($urandom)));
    send_request(make_request(OP_SET, 16'h8000, 16'h8000, 16'd2048, 16'($urandom)));
    send_request(make_request(OP_SET, 16'h7fff, 16'd2048, 16'hffff, 16'($urandom)));
    send_request(make_request(OP_SET, 16'd5760, 16'd4096, 16'd0, 16'($urandom)));
    send_request(make_request(OP_SET, 16'd480, 16'd0, 16'd4096, 16'($urandom)));
    send_request(make_request(OP_SET, 16'd100, 16'd4095, 16'd4097, 16'($urandom)));
    // hue deltas crossing zero and the extremes
    send_request(make_request(OP_ADD_HUE, 16'($urandom), 16'($urandom), 16'($urandom),
                              16'hff00));
    send_request(make_request(OP_ADD_HUE, 16'($urandom), 16'($urandom), 16'($urandom),
                              16'h7fff));
    send_request(make_request(OP_ADD_HUE, 16'($urandom), 16'($urandom), 16'($urandom),
                              16'h8000));
    // saturating adds on saturation and brightness
    send_request(make_request(OP_ADD_SAT, 16'($urandom), 16'($urandom), 16'($urandom),
                              16'h7fff));
    send_request(make_request(OP_ADD_SAT, 16'($urandom), 16'($urandom), 16'($urandom),
                              16'h7fff));
    send_request(make_request(OP_ADD_SAT, 16'($urandom), 16'($urandom), 16'($urandom),
                              16'h8000));
    send_request(make_request(OP_ADD_SAT, 16'($urandom), 16'($urandom), 16'($urandom),
                              16'h8000));
    send_request(make_request(OP_ADD_BRI, 16'($urandom), 16'($urandom), 16'($urandom),
                              16'h7fff));
    send_request(make_request(OP_ADD_BRI, 16'($urandom), 16'($urandom), 16'($urandom),
                              16'h7fff));
    send_request(make_request(OP_ADD_BRI, 16'($urandom), 16'($urandom), 16'($urandom),
                              16'h8000));
    send_request(make_request(OP_ADD_BRI, 16'($urandom), 16'($urandom), 16'($urandom),
                              16'h8000));
    send_request(make_request(OP_ADD_SAT, 16'($urandom), 16'($urandom), 16'($urandom),
                              16'd0));

    // random part, with a long receiver hold-off while requests keep coming
    hold_off_req = 1'b1;
    sent = 0;
    while (sent < RANDOM_REQS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        if (sent < RANDOM_REQS) begin
          send_request(random_request());
          sent++;
        end
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) idle_sender(gap);
    end
    in_valid = 1'b0;

    while (colors.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("requests: set %0d, hue add %0d, saturation add %0d, brightness add %0d",
             colors.op_count[OP_SET], colors.op_count[OP_ADD_HUE],
             colors.op_count[OP_ADD_SAT], colors.op_count[OP_ADD_BRI]);
    $display("colors checked %0d, long hold-offs %0d, mismatches %0d",
             colors.checked, hold_offs_done, colors.errors);
    if (colors.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
